// ===== rtl/core/rmcs_pkg.sv =====
// Shared types, constants and phase codes for the run-length mask decoder.
package rmcs_pkg;

  localparam int CW = 12;
  localparam int RXW = CW + 1;
  localparam int SPW = CW + 2;
  localparam int RUNW = 10;
  localparam int IN_DW = 8;
  localparam int OUT_DW = ((4 * CW + 7) / 8) * 8;
  localparam int CFG_IW = 3;
  localparam int NSLOT = 4;

  localparam logic [RUNW-1:0] ESC1_BASE = RUNW'(255);
  localparam logic [RUNW-1:0] ESC2_BASE = RUNW'(511);
  localparam logic [IN_DW-1:0] HDR_FIXED_OPAQUE = 8'h80;

  localparam logic [CW-1:0] RST_SURF_W = CW'(640);
  localparam logic [CW-1:0] RST_SURF_H = CW'(480);
  localparam logic [CW-1:0] RST_VIEW_W = CW'(640);
  localparam logic [CW-1:0] RST_VIEW_H = CW'(480);

  typedef enum logic [CFG_IW-1:0] {
    REG_SURF_W = 3'd0,
    REG_SURF_H = 3'd1,
    REG_VIEW_L = 3'd2,
    REG_VIEW_T = 3'd3,
    REG_VIEW_W = 3'd4,
    REG_VIEW_H = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_FRAME = 3'd0,
    PH_ROW   = 3'd1,
    PH_RUN   = 3'd2,
    PH_ESC1  = 3'd3,
    PH_ESC2  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CW-1:0] surf_w;
    logic [CW-1:0] surf_h;
    logic [CW-1:0] view_l;
    logic [CW-1:0] view_t;
    logic [CW-1:0] view_w;
    logic [CW-1:0] view_h;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] top;
    logic [CW-1:0] rows;
    logic [CW-1:0] left;
    logic [CW-1:0] length;
    logic          opaque;
  } rect_t;

  typedef struct packed {
    rect_t [NSLOT-1:0] rects;
    logic [NSLOT-1:0]  valid;
    logic              ended;
  } dec_out_t;

endpackage

// ===== rtl/core/rmcs_cfg_regs.sv =====
// Configuration register file for the run-length mask decoder.
module rmcs_cfg_regs import rmcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surf_w <= RST_SURF_W;
      cfg_r.surf_h <= RST_SURF_H;
      cfg_r.view_l <= '0;
      cfg_r.view_t <= '0;
      cfg_r.view_w <= RST_VIEW_W;
      cfg_r.view_h <= RST_VIEW_H;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SURF_W: cfg_r.surf_w <= cfg_data;
        REG_SURF_H: cfg_r.surf_h <= cfg_data;
        REG_VIEW_L: cfg_r.view_l <= cfg_data;
        REG_VIEW_T: cfg_r.view_t <= cfg_data;
        REG_VIEW_W: cfg_r.view_w <= cfg_data;
        REG_VIEW_H: cfg_r.view_h <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/rmcs_decoder.sv =====
// Decode state and per-byte rectangle generation.
module rmcs_decoder import rmcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [IN_DW-1:0] mask_byte,
  input  cfg_t             cfg,
  output dec_out_t         dec
);

  phase_t          phase_r, phase_nxt;
  logic [CW-1:0]   row_r, row_nxt;
  logic [RXW-1:0]  run_x_r, run_x_nxt;
  logic            pol_r, pol_nxt;
  logic            tog_r, tog_nxt;

  logic            is_frame, is_hdr, is_run;
  logic [RUNW-1:0] run_len;
  logic [CW-1:0]   row_base, cur_row;
  logic [CW-1:0]   eff_h;
  logic [CW:0]     row_inc;
  logic [SPW-1:0]  sw_x, start, right, fill_room;
  logic [RXW-1:0]  run_x_sum, run_x_after;
  logic [CW-1:0]   fill, th, lw;
  logic [CW:0]     bottom;
  logic            end_row, end_frame;
  logic            run_pol;

  always_comb begin
    is_frame = 1'b0;
    is_hdr = 1'b0;
    is_run = 1'b0;
    run_len = '0;
    case (phase_r)
      PH_ROW: is_hdr = 1'b1;
      PH_RUN: begin
        is_run = (mask_byte != '0);
        run_len = RUNW'(mask_byte);
      end
      PH_ESC1: begin
        is_run = (mask_byte != '0);
        run_len = ESC1_BASE + RUNW'(mask_byte);
      end
      PH_ESC2: begin
        is_run = 1'b1;
        run_len = ESC2_BASE + RUNW'(mask_byte);
      end
      default: begin
        is_frame = 1'b1;
        is_hdr = 1'b1;
      end
    endcase
  end

  assign row_base = is_frame ? '0 : row_r;
  assign cur_row = cfg.view_t + row_base;
  assign eff_h = (cfg.view_h == '0) ? CW'(1) : cfg.view_h;
  assign row_inc = {1'b0, row_base} + (CW+1)'(1);
  assign bottom = {1'b0, cfg.view_t} + {1'b0, eff_h};

  assign sw_x = SPW'(cfg.surf_w);
  assign start = SPW'(cfg.view_l) + SPW'(run_x_r);
  assign fill_room = sw_x - start;
  assign fill = (fill_room > SPW'(run_len)) ? CW'(run_len) : fill_room[CW-1:0];
  assign run_x_sum = run_x_r + RXW'(run_len);
  assign run_x_after = is_hdr ? '0 : (is_run ? run_x_sum : run_x_r);
  assign right = SPW'(cfg.view_l) + SPW'(run_x_after);

  assign th = (cfg.view_t < cfg.surf_h) ? cfg.view_t : cfg.surf_h;
  assign lw = (cfg.view_l < cfg.surf_w) ? cfg.view_l : cfg.surf_w;
  assign run_pol = pol_r;

  assign end_row = (is_hdr && cfg.view_w == '0) ||
                   (is_run && run_x_sum >= RXW'(cfg.view_w));
  assign end_frame = end_row && (row_inc >= {1'b0, eff_h});

  always_comb begin
    dec.rects[0].top = '0;
    dec.rects[0].rows = th;
    dec.rects[0].left = '0;
    dec.rects[0].length = cfg.surf_w;
    dec.rects[0].opaque = 1'b1;
    dec.valid[0] = is_frame && th != '0 && cfg.surf_w != '0;

    dec.rects[1].top = cur_row;
    dec.rects[1].rows = CW'(1);
    if (is_hdr) begin
      dec.rects[1].left = '0;
      dec.rects[1].length = lw;
      dec.rects[1].opaque = 1'b1;
      dec.valid[1] = lw != '0;
    end else begin
      dec.rects[1].left = start[CW-1:0];
      dec.rects[1].length = fill;
      dec.rects[1].opaque = run_pol;
      dec.valid[1] = is_run && sw_x > start;
    end

    dec.rects[2].top = cur_row;
    dec.rects[2].rows = CW'(1);
    dec.rects[2].left = right[CW-1:0];
    dec.rects[2].length = CW'(sw_x - right);
    dec.rects[2].opaque = 1'b1;
    dec.valid[2] = end_row && sw_x > right;

    dec.rects[3].top = bottom[CW-1:0];
    dec.rects[3].rows = CW'({1'b0, cfg.surf_h} - bottom);
    dec.rects[3].left = '0;
    dec.rects[3].length = cfg.surf_w;
    dec.rects[3].opaque = 1'b1;
    dec.valid[3] = end_frame && {1'b0, cfg.surf_h} > bottom && cfg.surf_w != '0;

    dec.ended = end_frame;
  end

  always_comb begin
    phase_nxt = phase_r;
    row_nxt = row_base;
    run_x_nxt = run_x_after;
    pol_nxt = pol_r;
    tog_nxt = tog_r;
    if (is_hdr) begin
      pol_nxt = mask_byte[IN_DW-1];
      tog_nxt = (mask_byte != '0) && (mask_byte != HDR_FIXED_OPAQUE);
      phase_nxt = PH_RUN;
    end else if (is_run) begin
      if (tog_r) begin
        pol_nxt = !pol_r;
      end
      phase_nxt = PH_RUN;
    end else if (phase_r == PH_RUN) begin
      phase_nxt = PH_ESC1;
    end else begin
      phase_nxt = PH_ESC2;
    end
    if (end_row) begin
      run_x_nxt = '0;
      if (end_frame) begin
        row_nxt = '0;
        phase_nxt = PH_FRAME;
      end else begin
        row_nxt = row_inc[CW-1:0];
        phase_nxt = PH_ROW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FRAME;
      row_r <= '0;
      run_x_r <= '0;
      pol_r <= 1'b0;
      tog_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      row_r <= row_nxt;
      run_x_r <= run_x_nxt;
      pol_r <= pol_nxt;
      tog_r <= tog_nxt;
    end
  end

endmodule

// ===== rtl/core/rmcs_out_buf.sv =====
// Result register holding up to four rectangles of one byte and sending them in order.
module rmcs_out_buf import rmcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dec_out_t          dec,
  output logic              can_load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  rect_t            slot_r [NSLOT];
  logic [NSLOT-1:0] pend_r, pend_nxt;
  logic             ended_r;
  logic [1:0]       head;
  logic [NSLOT-1:0] rest;
  logic             is_last;
  rect_t            cur;

  always_comb begin
    head = 2'd3;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        head = 2'(i);
      end
    end
  end

  always_comb begin
    rest = pend_r;
    rest[head] = 1'b0;
  end

  assign is_last = (rest == '0);
  assign cur = slot_r[head];
  assign out_tvalid = (pend_r != '0);
  assign out_tlast = is_last;
  assign out_tuser = {ended_r && is_last, cur.opaque};
  assign out_tdata = OUT_DW'({cur.length, cur.left, cur.rows, cur.top});
  assign can_load = !out_tvalid || (out_tready && is_last);

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = dec.valid;
    end else if (out_tvalid && out_tready) begin
      pend_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_r[i] <= dec.rects[i];
      end
      ended_r <= dec.ended;
    end
  end

endmodule

// ===== rtl/core/rle_mask_to_coverage_spans_top.sv =====
// Top level of the run-length mask to coverage rectangle decoder.
//
//   channel | direction | transfer when            | payload
//   in_     | input     | in_tvalid & in_tready    | tdata[7:0] mask byte
//   out_    | output    | out_tvalid & out_tready  | tdata rectangle, tuser flags, tlast
//   cfg_    | input     | cfg_valid & cfg_ready    | cfg_index register, cfg_data value
//
// A byte is decoded in the cycle it is transferred and its rectangles appear in the next cycle.
// A byte's rectangles (0 to 4 of them) hold the result register until the last one is taken,
// so a stream of single-result bytes runs at one byte per clock while out_tready stays high.
// Reset clears the decode state and pending rectangles and loads the register defaults; nothing else needs clearing.
// A stalled output holds its rectangle; input is refused until the last one is taken.
module rle_mask_to_coverage_spans_top import rmcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [7:0] mask_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [11:0] rect_top, [23:12] rect_rows,
                                        // [35:24] rect_left, [47:36] rect_length
  output logic [1:0]        out_tuser,  // [0] opaque, [1] frame_end
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_data
);

  cfg_t     cfg;
  dec_out_t dec;
  logic     can_load;
  logic     step;

  assign in_tready = can_load;
  assign step = in_tvalid && can_load;

  rmcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rmcs_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .mask_byte (in_tdata),
    .cfg       (cfg),
    .dec       (dec)
  );

  rmcs_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .dec        (dec),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_in_only_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid || (out_tready && out_tlast))
    else $error("input transfer while earlier rectangles remain");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("frame end flagged on a rectangle that is not the last of its byte");

  a_no_empty_rect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*CW-1:CW] != '0 && out_tdata[4*CW-1:3*CW] != '0)
    else $error("zero-size rectangle sent");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the run-length mask decoder: byte driver, rectangle monitor, model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmcs_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 80;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_BYTES = 25;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [CW-1:0] top;
    logic [CW-1:0] rows;
    logic [CW-1:0] left;
    logic [CW-1:0] len;
    logic          opaque;
    logic          frame_end;
    logic          last;
  } span_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CW-1:0]     cfg_data = '0;

  rle_mask_to_coverage_spans_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Decoder model state.
  cfg_t           mask_cfg = '{surf_w: RST_SURF_W, surf_h: RST_SURF_H, view_l: '0,
                               view_t: '0, view_w: RST_VIEW_W, view_h: RST_VIEW_H};
  phase_t         dec_phase = PH_FRAME;
  logic [CW-1:0]  dec_row = '0;
  logic [RXW-1:0] dec_x = '0;
  logic           dec_opq = 1'b0;
  logic           dec_tog = 1'b0;
  logic [RUNW-1:0] dec_esc = '0;
  bit             frame_done;

  span_t          byte_rects[$];
  span_t          rects_due[$];
  logic [7:0]     mask_bytes_pending[$];

  int unsigned    src_wait;
  int unsigned    hold_left;
  bit             hold_request;
  bit             quiet_flow;
  int unsigned    quiet_cycles;
  int unsigned    fail_count;
  int unsigned    bytes_queued;
  int unsigned    bytes_taken;
  int unsigned    rects_seen;
  int unsigned    clear_seen;
  int unsigned    frames_seen;
  int unsigned    settings_used;
  span_t          want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned view_rows();
    return (mask_cfg.view_h == 0) ? 1 : mask_cfg.view_h;
  endfunction

  function automatic int unsigned row_now();
    return mask_cfg.view_t + dec_row;
  endfunction

  function automatic void add_span(int unsigned top, int unsigned rows, int unsigned left,
                                   int unsigned len, bit opq);
    span_t s;
    if (rows == 0 || len == 0 || byte_rects.size() >= NSLOT) return;
    s.top = top[CW-1:0];
    s.rows = rows[CW-1:0];
    s.left = left[CW-1:0];
    s.len = len[CW-1:0];
    s.opaque = opq;
    s.frame_end = 1'b0;
    s.last = 1'b0;
    byte_rects.push_back(s);
  endfunction

  function automatic void close_row();
    int unsigned right;
    int unsigned bottom;
    int unsigned h;
    right = mask_cfg.view_l + dec_x;
    if (mask_cfg.surf_w > right)
      add_span(row_now(), 1, right, mask_cfg.surf_w - right, 1'b1);
    dec_row = dec_row + 1'b1;
    dec_x = '0;
    h = view_rows();
    if (dec_row >= h) begin
      bottom = mask_cfg.view_t + h;
      if (mask_cfg.surf_h > bottom)
        add_span(bottom, mask_cfg.surf_h - bottom, 0, mask_cfg.surf_w, 1'b1);
      dec_row = '0;
      dec_phase = PH_FRAME;
      frame_done = 1'b1;
    end else begin
      dec_phase = PH_ROW;
    end
  endfunction

  function automatic void take_run(int unsigned len);
    int unsigned start;
    int unsigned fill;
    start = mask_cfg.view_l + dec_x;
    if (mask_cfg.surf_w > start) begin
      fill = mask_cfg.surf_w - start;
      if (fill > len) fill = len;
      add_span(row_now(), 1, start, fill, dec_opq);
    end
    dec_x = RXW'(dec_x + len);
    if (dec_tog) dec_opq = ~dec_opq;
    dec_phase = PH_RUN;
    dec_esc = '0;
    if (dec_x >= mask_cfg.view_w) close_row();
  endfunction

  function automatic void take_header(logic [7:0] b);
    int unsigned lw;
    dec_opq = b[7];
    dec_tog = (b != 8'h00) && (b != HDR_FIXED_OPAQUE);
    dec_x = '0;
    dec_esc = '0;
    lw = (mask_cfg.view_l < mask_cfg.surf_w) ? mask_cfg.view_l : mask_cfg.surf_w;
    add_span(row_now(), 1, 0, lw, 1'b1);
    dec_phase = PH_RUN;
    if (mask_cfg.view_w == 0) close_row();
  endfunction

  function automatic void decode_mask_byte(logic [7:0] b);
    int unsigned th;
    span_t s;
    byte_rects.delete();
    frame_done = 1'b0;
    case (dec_phase)
      PH_ROW: take_header(b);
      PH_RUN: begin
        if (b != 0) take_run(b);
        else begin
          dec_esc = ESC1_BASE;
          dec_phase = PH_ESC1;
        end
      end
      PH_ESC1: begin
        if (b != 0) take_run(dec_esc + b);
        else begin
          dec_esc = ESC2_BASE;
          dec_phase = PH_ESC2;
        end
      end
      PH_ESC2: take_run(dec_esc + b);
      default: begin
        dec_row = '0;
        th = (mask_cfg.view_t < mask_cfg.surf_h) ? mask_cfg.view_t : mask_cfg.surf_h;
        add_span(0, th, 0, mask_cfg.surf_w, 1'b1);
        take_header(b);
      end
    endcase
    for (int i = 0; i < byte_rects.size(); i++) begin
      s = byte_rects[i];
      if (i == byte_rects.size() - 1) begin
        s.last = 1'b1;
        s.frame_end = frame_done;
      end
      rects_due.push_back(s);
    end
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned exp);
    if (got != exp)
      report_mismatch($sformatf("rectangle %0d %s is %0d, expected %0d",
                                rects_seen, name, got, exp));
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_mask_byte(in_tdata);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          in_tvalid <= 1'b0;
        end else if (mask_bytes_pending.size() > 0) begin
          in_tdata <= mask_bytes_pending.pop_front();
          in_tvalid <= 1'b1;
          src_wait = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (rects_due.size() == 0) begin
        report_mismatch("rectangle transfer with nothing expected");
      end else begin
        want = rects_due.pop_front();
        check_field("rect_top", out_tdata[CW-1:0], want.top);
        check_field("rect_rows", out_tdata[2*CW-1:CW], want.rows);
        check_field("rect_left", out_tdata[3*CW-1:2*CW], want.left);
        check_field("rect_length", out_tdata[4*CW-1:3*CW], want.len);
        check_field("opaque", out_tuser[0], want.opaque);
        check_field("frame_end", out_tuser[1], want.frame_end);
        check_field("last", out_tlast, want.last);
        if (!want.opaque) clear_seen++;
        if (want.frame_end) frames_seen++;
      end
      rects_seen++;
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (quiet_flow) begin
      out_tready <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        hold_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL rle_mask_to_coverage_spans_top");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SURF_W: mask_cfg.surf_w = val;
      REG_SURF_H: mask_cfg.surf_h = val;
      REG_VIEW_L: mask_cfg.view_l = val;
      REG_VIEW_T: mask_cfg.view_t = val;
      REG_VIEW_W: mask_cfg.view_w = val;
      REG_VIEW_H: mask_cfg.view_h = val;
      default: ;
    endcase
  endtask

  task automatic queue_byte(logic [7:0] b);
    mask_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_run(int unsigned len);
    if (len <= 255) begin
      queue_byte(len[7:0]);
    end else if (len <= 510) begin
      queue_byte(8'h00);
      queue_byte(8'(len - 255));
    end else begin
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(8'(len - 511));
    end
  endtask

  // Header plus runs up to the view width, now and then preceded by a stray byte or cut short.
  task automatic queue_row();
    int unsigned r;
    int unsigned x;
    int unsigned len;
    bit cut;
    r = $urandom_range(0, 99);
    if (r < 6) queue_byte(8'($urandom_range(0, 255)));
    cut = (r >= 94);
    r = $urandom_range(0, 99);
    queue_byte((r < 15) ? 8'h00 : (r < 30) ? HDR_FIXED_OPAQUE : 8'($urandom_range(0, 255)));
    x = 0;
    while (x < mask_cfg.view_w) begin
      r = $urandom_range(0, 99);
      len = (r < 50) ? $urandom_range(1, 60) : (r < 80) ? $urandom_range(1, 255)
                                                      : $urandom_range(256, 766);
      queue_run(len);
      x += len;
      if (cut) break;
    end
  endtask

  task automatic drain();
    while (mask_bytes_pending.size() != 0 || in_tvalid || rects_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A single byte with a one-row, zero-width view ends whatever frame is open.
  task automatic flush_frame();
    if (dec_phase != PH_FRAME) begin
      write_reg(REG_VIEW_W, '0);
      write_reg(REG_VIEW_H, CW'(1));
      queue_byte(8'h01);
      drain();
    end
  endtask

  task automatic new_setting(int unsigned sw, int unsigned sh, int unsigned vl,
                             int unsigned vt, int unsigned vw, int unsigned vh);
    flush_frame();
    write_reg(REG_SURF_W, CW'(sw));
    write_reg(REG_SURF_H, CW'(sh));
    write_reg(REG_VIEW_L, CW'(vl));
    write_reg(REG_VIEW_T, CW'(vt));
    write_reg(REG_VIEW_W, CW'(vw));
    write_reg(REG_VIEW_H, CW'(vh));
    settings_used++;
  endtask

  task automatic run_rows(int unsigned nbytes);
    int unsigned target;
    target = bytes_queued + nbytes;
    while (bytes_queued < target) queue_row();
  endtask

  initial begin : stimulus
    logic [7:0] directed[$];
    int unsigned sw;
    int unsigned sh;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Escapes of every kind, fixed and toggling headers of both signs, borders and clipping.
    new_setting(600, 40, 8, 4, 520, 4);
    directed = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                 8'h80, 8'h64, 8'h00, 8'h00, 8'hFF,
                 8'h7F, 8'h01, 8'h02, 8'h00, 8'hFF, 8'h07,
                 8'h81, 8'h00, 8'h00, 8'h09,
                 8'hFE};
    foreach (directed[i]) queue_byte(directed[i]);
    drain();

    new_setting(100, 50, 10, 5, 0, 3);
    run_rows(PHASE_BYTES);
    drain();

    quiet_flow = 1'b1;
    new_setting(4095, 4095, 0, 0, 300, 0);
    run_rows(PHASE_BYTES);
    drain();
    quiet_flow = 1'b0;

    new_setting(1, 1, 4095, 4095, 40, 2);
    run_rows(PHASE_BYTES);
    drain();

    new_setting(200, 4095, 300, 10, 100, 3);
    run_rows(PHASE_BYTES);
    drain();

    new_setting(4095, 4095, 4095, 4095, 4095, 4095);
    run_rows(PHASE_BYTES);
    drain();

    quiet_flow = 1'b1;
    new_setting(64, 32, 4, 2, 20, 2);
    run_rows(PHASE_BYTES);
    hold_request = 1'b1;
    drain();
    quiet_flow = 1'b0;

    repeat (6) begin
      sw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 700);
      sh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 200);
      new_setting(sw, sh,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(4000, 4095)
                                              : $urandom_range(0, 100),
                  $urandom_range(0, 500), $urandom_range(0, 4));
      run_rows(PHASE_BYTES);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    foreach (rects_due[i]) report_mismatch("expected rectangle never arrived");
    $display("Decoded %0d mask bytes under %0d register settings into %0d rectangles,",
             bytes_taken, settings_used, rects_seen);
    $display("of which %0d were clear and %0d closed a frame.", clear_seen, frames_seen);
    if (fail_count == 0) begin
      $display("PASS rle_mask_to_coverage_spans_top");
    end else begin
      $display("FAIL rle_mask_to_coverage_spans_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rmcs_pkg.sv
rtl/core/rmcs_cfg_regs.sv
rtl/core/rmcs_decoder.sv
rtl/core/rmcs_out_buf.sv
rtl/core/rle_mask_to_coverage_spans_top.sv
tb/sv/testbench.sv
